>>> hdl/ssa_pkg.sv
// Shared sizes, command codes and the queued operation type for the
// sparse sign sketch accumulator. No dependencies.
package ssa_pkg;

  // Problem sizes
  localparam int SKETCH_LEN  = 64;
  localparam int INPUT_MAX   = 1024;
  localparam int MAX_ZETA    = 8;
  localparam int OTHER_MAX   = 16;

  // Depth of the queue between front and back
  localparam int FIFO_DEPTH  = 2;

  // Fixed port widths
  localparam int CMD_W      = 2;
  localparam int IDX_IN_W   = 10;
  localparam int SLOT_IN_W  = 3;
  localparam int OC_IN_W    = 4;
  localparam int POS_IN_W   = 6;
  localparam int VAL_W      = 32;
  localparam int ACC_W      = 48;
  localparam int ZETA_IN_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Derived widths and depths
  localparam int TGT_W     = (SKETCH_LEN > 1) ? $clog2(SKETCH_LEN) : 1;
  localparam int TBL_DEPTH = INPUT_MAX * MAX_ZETA;
  localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int TBL_W     = TGT_W + 1;
  localparam int ACC_DEPTH = SKETCH_LEN * OTHER_MAX;
  localparam int ACC_AW    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
  localparam int ZETA_W    = $clog2(MAX_ZETA + 1);
  localparam int FIFO_PW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW   = $clog2(FIFO_DEPTH + 1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  // Configuration register indexes (orientation register changes no storage)
  localparam logic [CFG_IDX_W-1:0] REG_ZETA = 1'd0;

  // Classified command as it travels through the queue
  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic                     ok;     // in range and has work to do
    logic [ZETA_W-1:0]        zeta;   // clamped slot count
    logic [IDX_IN_W-1:0]      idx;
    logic [SLOT_IN_W-1:0]     slot;
    logic [OC_IN_W-1:0]       oc;
    logic [POS_IN_W-1:0]      pos;
    logic                     neg;
    logic signed [VAL_W-1:0]  value;
  } op_t;

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [TBL_AW-1:0] i,
                                                 input logic [TBL_AW-1:0] s);
    tbl_addr = TBL_AW'(i * MAX_ZETA + s);
  endfunction

  function automatic logic [ACC_AW-1:0] acc_addr(input logic [ACC_AW-1:0] t,
                                                 input logic [ACC_AW-1:0] oc);
    acc_addr = ACC_AW'(t * OTHER_MAX + oc);
  endfunction

endpackage

>>> hdl/ssa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ssa_front.sv
// Front end: accepts commands, holds the slot-count register and
// classifies each command into an op_t for the queue. Uses ssa_pkg.
module ssa_front import ssa_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [CMD_W-1:0]            cmd,
  input  logic [IDX_IN_W-1:0]         input_index,
  input  logic [SLOT_IN_W-1:0]        slot,
  input  logic [OC_IN_W-1:0]          other_coord,
  input  logic [POS_IN_W-1:0]         sketch_pos,
  input  logic                        negative,
  input  logic signed [VAL_W-1:0]     value,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        fifo_full,
  input  logic                        back_init,
  output logic                        busy,
  output logic                        push,
  output op_t                         op
);

  logic [ZETA_IN_W-1:0] zeta_reg;
  logic [ZETA_W-1:0]    zeta_clamped;
  logic                 idx_ok;
  logic                 slot_ok;
  logic                 oc_ok;
  logic                 pos_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      zeta_reg <= ZETA_IN_W'(1);
    end else if (cfg_we && cfg_index == REG_ZETA) begin
      zeta_reg <= cfg_data[ZETA_IN_W-1:0];
    end
  end

  assign zeta_clamped = (32'(zeta_reg) > MAX_ZETA) ? ZETA_W'(MAX_ZETA) : ZETA_W'(zeta_reg);

  assign idx_ok  = 32'(input_index) < INPUT_MAX;
  assign slot_ok = 32'(slot) < MAX_ZETA;
  assign oc_ok   = 32'(other_coord) < OTHER_MAX;
  assign pos_ok  = 32'(sketch_pos) < SKETCH_LEN;

  // Hold off while the queue is full or the accumulators are being wiped after reset
  assign busy = fifo_full | back_init;
  assign push = start & ~busy;

  always_comb begin
    op.cmd   = cmd;
    op.zeta  = zeta_clamped;
    op.idx   = input_index;
    op.slot  = slot;
    op.oc    = other_coord;
    op.pos   = sketch_pos;
    op.neg   = negative;
    op.value = value;
    case (cmd)
      CMD_LOAD:  op.ok = idx_ok & slot_ok & pos_ok;
      CMD_ACC:   op.ok = idx_ok & oc_ok & (zeta_clamped != '0);
      CMD_CLEAR: op.ok = 1'b1;
      CMD_READ:  op.ok = pos_ok & oc_ok;
      default:   op.ok = 1'b0;
    endcase
  end

endmodule

>>> hdl/ssa_fifo.sv
// Short queue of classified commands between front and back.
// Uses ssa_pkg.
module ssa_fifo import ssa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head,
  output logic empty,
  output logic full
);

  op_t                 store [FIFO_DEPTH];
  logic [FIFO_PW-1:0]  wr_ptr;
  logic [FIFO_PW-1:0]  rd_ptr;
  logic [FIFO_CW-1:0]  count;
  logic                do_push;
  logic                do_pop;

  assign empty   = (count == '0);
  assign full    = (count == FIFO_CW'(FIFO_DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/ssa_back.sv
// Back end: executes queued commands against the slot table and the
// accumulator memory. Uses ssa_pkg and ssa_ram.
module ssa_back import ssa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  op_t                     head,
  input  logic                    empty,
  output logic                    pop,
  output logic                    init,
  output logic                    done,
  output logic signed [ACC_W-1:0] read_data,
  output logic                    saturated
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CLEAR = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic [2:0]               state;
  logic [ACC_AW-1:0]        clr_addr;
  op_t                      cur;
  logic [ZETA_W-1:0]        iss_z;
  logic                     t1_v;
  logic                     t2_v;
  logic                     t2_neg;
  logic [ACC_AW-1:0]        t2_addr;
  logic                     lw_v;
  logic [ACC_AW-1:0]        lw_addr;
  logic signed [ACC_W-1:0]  lw_data;
  logic                     sat_acc;

  logic                     tbl_we;
  logic [TBL_AW-1:0]        tbl_waddr;
  logic [TBL_W-1:0]         tbl_wdata;
  logic [TBL_AW-1:0]        tbl_raddr;
  logic [TBL_W-1:0]         tbl_rdata;
  logic [TGT_W-1:0]         tgt;
  logic                     tgt_ok;

  logic                     acc_we;
  logic [ACC_AW-1:0]        acc_waddr;
  logic signed [ACC_W-1:0]  acc_wdata;
  logic [ACC_AW-1:0]        acc_raddr;
  logic signed [ACC_W-1:0]  acc_rdata;

  logic signed [ACC_W-1:0]  old_val;
  logic signed [VAL_W:0]    addend;
  logic signed [ACC_W:0]    sum;
  logic                     ovf;
  logic signed [ACC_W-1:0]  clipped;
  logic                     sweep_last;

  assign init       = (state == ST_INIT);
  assign pop        = (state == ST_IDLE) && !empty;
  assign sweep_last = (clr_addr == ACC_AW'(ACC_DEPTH - 1));

  // Slot table: target in the low bits, sign on top
  assign tbl_we    = pop && head.cmd == CMD_LOAD && head.ok;
  assign tbl_waddr = tbl_addr(TBL_AW'(head.idx), TBL_AW'(head.slot));
  assign tbl_wdata = {head.neg, TGT_W'(head.pos)};
  assign tbl_raddr = tbl_addr(TBL_AW'(cur.idx), TBL_AW'(iss_z));
  assign tgt       = tbl_rdata[TGT_W-1:0];
  assign tgt_ok    = 32'(tgt) < SKETCH_LEN;

  ssa_ram #(.WIDTH(TBL_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Forward the write of the previous cycle; the RAM read may have missed it
  assign old_val = (lw_v && lw_addr == t2_addr) ? lw_data : acc_rdata;
  assign addend  = t2_neg ? -(VAL_W+1)'(cur.value) : (VAL_W+1)'(cur.value);
  assign sum     = (ACC_W+1)'(old_val) + (ACC_W+1)'(addend);
  assign ovf     = sum[ACC_W] != sum[ACC_W-1];
  assign clipped = ovf ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = clr_addr;
    acc_wdata = '0;
    if (state == ST_INIT || state == ST_CLEAR) begin
      acc_we = 1'b1;
    end else if (state == ST_ACC && t2_v) begin
      acc_we    = 1'b1;
      acc_waddr = t2_addr;
      acc_wdata = clipped;
    end
  end

  assign acc_raddr = (state == ST_ACC) ? acc_addr(ACC_AW'(tgt), ACC_AW'(cur.oc))
                                       : acc_addr(ACC_AW'(head.pos), ACC_AW'(head.oc));

  ssa_ram #(.WIDTH(ACC_W), .DEPTH(ACC_DEPTH)) u_acc (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == ST_ACC) begin
      t2_addr <= acc_raddr;
      t2_neg  <= tbl_rdata[TGT_W];
      if (t2_v) begin
        lw_addr <= t2_addr;
        lw_data <= clipped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      clr_addr  <= '0;
      iss_z     <= '0;
      t1_v      <= 1'b0;
      t2_v      <= 1'b0;
      lw_v      <= 1'b0;
      sat_acc   <= 1'b0;
      done      <= 1'b0;
      read_data <= '0;
      saturated <= 1'b0;
    end else begin
      done <= 1'b0;
      lw_v <= (state == ST_ACC) && t2_v;
      case (state)
        ST_INIT: begin
          clr_addr <= sweep_last ? '0 : clr_addr + 1'b1;
          if (sweep_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!empty) begin
            case (head.cmd)
              CMD_ACC: begin
                if (head.ok) begin
                  state   <= ST_ACC;
                  iss_z   <= '0;
                  t1_v    <= 1'b0;
                  t2_v    <= 1'b0;
                  sat_acc <= 1'b0;
                end else begin
                  done      <= 1'b1;
                  read_data <= '0;
                  saturated <= 1'b0;
                end
              end
              CMD_CLEAR: begin
                state    <= ST_CLEAR;
                clr_addr <= '0;
              end
              CMD_READ: begin
                state <= ST_READ;
              end
              default: begin
                done      <= 1'b1;
                read_data <= '0;
                saturated <= 1'b0;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr <= sweep_last ? '0 : clr_addr + 1'b1;
          if (sweep_last) begin
            state     <= ST_IDLE;
            done      <= 1'b1;
            read_data <= '0;
            saturated <= 1'b0;
          end
        end
        ST_READ: begin
          state     <= ST_IDLE;
          done      <= 1'b1;
          read_data <= cur.ok ? acc_rdata : '0;
          saturated <= 1'b0;
        end
        ST_ACC: begin
          // Three-step pipe: table read, accumulator read, add and write back
          t1_v <= iss_z < cur.zeta;
          if (iss_z < cur.zeta) begin
            iss_z <= iss_z + 1'b1;
          end
          t2_v <= t1_v && tgt_ok;
          if (t2_v && ovf) begin
            sat_acc <= 1'b1;
          end
          if (iss_z == cur.zeta && !t1_v && !t2_v) begin
            state     <= ST_IDLE;
            done      <= 1'b1;
            read_data <= '0;
            saturated <= sat_acc;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/sparse_sign_sketch_accumulator.sv
// Sparse sign sketch accumulator, top level.
// Depends on ssa_pkg, ssa_front, ssa_fifo, ssa_back (which uses ssa_ram).
//
// Usage:
//   Commands enter on start while busy is low: load a slot-table entry,
//   accumulate one element into its zeta target accumulators, clear all
//   accumulators, or read one accumulator. Every command returns one result
//   on read_data/saturated, marked by a one-cycle done pulse; the receiver
//   must take it in that cycle, since the block never waits on it.
//   Configuration writes (cfg_we, cfg_index, cfg_data) land at once; the
//   user must issue them only while no command is in flight, which the
//   block does not enforce. Register 0 is the slot count zeta, register 1
//   the orientation, which leaves the layout unchanged. A two-entry queue
//   lets commands be taken while the back end works. Accumulate handles one
//   slot per cycle through the accumulator memory's single read-modify-write
//   path, and clear wipes one accumulator entry per cycle. After reset busy
//   stays high while the same sweep zeroes the accumulators; the slot table
//   is not cleared.
module sparse_sign_sketch_accumulator import ssa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [IDX_IN_W-1:0]      input_index,
  input  logic [SLOT_IN_W-1:0]     slot,
  input  logic [OC_IN_W-1:0]       other_coord,
  input  logic [POS_IN_W-1:0]      sketch_pos,
  input  logic                     negative,
  input  logic signed [VAL_W-1:0]  value,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output logic                     done,
  output logic signed [ACC_W-1:0]  read_data,
  output logic                     saturated
);

  logic push;
  op_t  push_op;
  op_t  head;
  logic empty;
  logic full;
  logic pop;
  logic init;

  ssa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .input_index (input_index),
    .slot        (slot),
    .other_coord (other_coord),
    .sketch_pos  (sketch_pos),
    .negative    (negative),
    .value       (value),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fifo_full   (full),
    .back_init   (init),
    .busy        (busy),
    .push        (push),
    .op          (push_op)
  );

  ssa_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  ssa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .init      (init),
    .done      (done),
    .read_data (read_data),
    .saturated (saturated)
  );

endmodule
